>>> rtl/core/nge_pkg.sv
// Package for the neighbor gradient edge filter core.
// Holds sizes, register codes, the configuration struct and shared helpers.
// Depends on nothing; every other core file except nge_ram imports it.
package nge_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_BORDER    = 5;
    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_INTENSITY = 5;
    localparam int RING_ROWS     = MAX_BORDER + 1;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int FW_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS   = 16;
    localparam int RMOD_BITS  = $clog2(RING_ROWS);
    localparam int RING_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int PIX_BITS   = 64;
    localparam int CH_BITS    = 16;
    localparam int SQ_W       = 38;
    localparam int SQRT_STEPS = SQ_W / 2;

    localparam logic [CH_BITS-1:0] SMAX_WIDE  = CH_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [CH_BITS-1:0] SMAX_NARROW = CH_BITS'(255);

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_EFFECT_MODE  = 3'd2,
        REG_INTENSITY    = 3'd3,
        REG_BORDER_WIDTH = 3'd4,
        REG_SIXTEEN_BIT  = 3'd5
    } reg_index_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [FW_BITS-1:0]  frame_width;
        logic [ROW_BITS-1:0] frame_height;
        logic                effect_mode;
        logic [2:0]          intensity;
        logic [2:0]          border_width;
        logic                sixteen_bit;
    } cfg_t;

    function automatic logic [RING_AW-1:0] ring_addr(input logic [RMOD_BITS-1:0] rmod,
                                                     input logic [COL_BITS-1:0] col);
        ring_addr = RING_AW'(rmod) * RING_AW'(MAX_WIDTH) + RING_AW'(col);
    endfunction

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_state_t;

    function automatic sqrt_state_t sqrt_step(input sqrt_state_t s, input logic [SQ_W-1:0] bitv);
        sqrt_state_t o;
        logic [SQ_W-1:0] trial;
        trial = s.root + bitv;
        if (s.rem >= trial)
        begin
            o.rem  = s.rem - trial;
            o.root = (s.root >> 1) + bitv;
        end
        else
        begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        sqrt_step = o;
    endfunction

endpackage

>>> rtl/core/nge_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the row ring copies.
module nge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/nge_cfg.sv
// APB register bank of the edge filter: saturates writes, returns values on reads.
// Depends on nge_pkg.
module nge_cfg
    import nge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    reg_index_t idx;
    logic wr;
    logic [10:0] fw_raw;
    logic [2:0]  in_raw;
    logic [2:0]  bw_raw;

    assign idx    = reg_index_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign fw_raw = pwdata[10:0];
    assign in_raw = pwdata[2:0];
    assign bw_raw = pwdata[2:0];
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_FRAME_WIDTH:
                begin
                    if (fw_raw == 11'd0)
                        cfg_next.frame_width = FW_BITS'(1);
                    else if (32'(fw_raw) > 32'(MAX_WIDTH))
                        cfg_next.frame_width = FW_BITS'(MAX_WIDTH);
                    else
                        cfg_next.frame_width = FW_BITS'(fw_raw);
                end
                REG_FRAME_HEIGHT:
                begin
                    if (pwdata[15:0] == 16'd0)
                        cfg_next.frame_height = ROW_BITS'(1);
                    else
                        cfg_next.frame_height = pwdata[15:0];
                end
                REG_EFFECT_MODE:
                    cfg_next.effect_mode = pwdata[0];
                REG_INTENSITY:
                begin
                    if (32'(in_raw) > 32'(MAX_INTENSITY))
                        cfg_next.intensity = 3'(MAX_INTENSITY);
                    else
                        cfg_next.intensity = in_raw;
                end
                REG_BORDER_WIDTH:
                begin
                    if (bw_raw == 3'd0)
                        cfg_next.border_width = 3'd1;
                    else if (32'(bw_raw) > 32'(MAX_BORDER))
                        cfg_next.border_width = 3'(MAX_BORDER);
                    else
                        cfg_next.border_width = bw_raw;
                end
                REG_SIXTEEN_BIT:
                    cfg_next.sixteen_bit = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= FW_BITS'(MAX_WIDTH);
            cfg_reg.frame_height <= ROW_BITS'(1);
            cfg_reg.effect_mode  <= 1'b0;
            cfg_reg.intensity    <= 3'd3;
            cfg_reg.border_width <= (MAX_BORDER < 2) ? 3'(MAX_BORDER) : 3'd2;
            cfg_reg.sixteen_bit  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            REG_EFFECT_MODE:  prdata = 32'(cfg_reg.effect_mode);
            REG_INTENSITY:    prdata = 32'(cfg_reg.intensity);
            REG_BORDER_WIDTH: prdata = 32'(cfg_reg.border_width);
            REG_SIXTEEN_BIT:  prdata = 32'(cfg_reg.sixteen_bit);
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/nge_fetch.sv
// Raster counters, row ring and neighbor fetch of the edge filter.
// Depends on nge_pkg and nge_ram; delivers center, right and down pixels one stage later.
module nge_fetch
    import nge_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                adv,
    input  logic                acc,
    input  logic                op,
    input  logic [PIX_BITS-1:0] pix,
    output logic                f_valid,
    output logic                f_done,
    output logic [PIX_BITS-1:0] c_pix,
    output logic [PIX_BITS-1:0] r_pix,
    output logic [PIX_BITS-1:0] d_pix
);

    logic [COL_BITS-1:0]  in_col_reg, in_col_next;
    logic [ROW_BITS-1:0]  in_row_reg, in_row_next;
    logic [RMOD_BITS-1:0] in_rmod_reg, in_rmod_next;
    logic [COL_BITS-1:0]  out_col_reg, out_col_next;
    logic [ROW_BITS-1:0]  out_row_reg, out_row_next;
    logic [RMOD_BITS-1:0] out_rmod_reg, out_rmod_next;
    logic                 tail_reg, tail_next;

    logic                 is_pixel;
    logic                 emit;
    logic                 done;
    logic                 last;
    logic [COL_BITS-1:0]  x;
    logic [ROW_BITS-1:0]  y;
    logic [RMOD_BITS-1:0] ymod;
    logic [FW_BITS-1:0]   fw_m1;
    logic [ROW_BITS-1:0]  fh_m1;
    logic [FW_BITS-1:0]   room_x;
    logic [ROW_BITS-1:0]  room_y;
    logic [2:0]           ox;
    logic [2:0]           oy;
    logic [RMOD_BITS:0]   dsum;
    logic [RMOD_BITS-1:0] dmod;
    logic [RING_AW-1:0]   waddr;
    logic [RING_AW-1:0]   addr_c, addr_r, addr_d;

    logic                 valid1_reg;
    logic                 done1_reg;
    logic                 hit_c_reg, hit_r_reg, hit_d_reg;
    logic [PIX_BITS-1:0]  wdata_reg;
    logic [PIX_BITS-1:0]  q_c, q_r, q_d;

    assign is_pixel = (opcode_t'(op) == OP_PIXEL);
    assign fw_m1    = cfg.frame_width - FW_BITS'(1);
    assign fh_m1    = cfg.frame_height - ROW_BITS'(1);

    always_comb
    begin
        if (is_pixel && tail_reg)
        begin
            x    = '0;
            y    = '0;
            ymod = '0;
        end
        else
        begin
            x    = out_col_reg;
            y    = out_row_reg;
            ymod = out_rmod_reg;
        end
        emit = is_pixel ? (in_row_reg >= ROW_BITS'(cfg.border_width)) : tail_reg;

        room_x = fw_m1 - FW_BITS'(x);
        if (FW_BITS'(x) >= fw_m1)
            ox = 3'd0;
        else if (room_x < FW_BITS'(cfg.border_width))
            ox = room_x[2:0];
        else
            ox = cfg.border_width;

        room_y = fh_m1 - y;
        if (y >= fh_m1)
            oy = 3'd0;
        else if (room_y < ROW_BITS'(cfg.border_width))
            oy = room_y[2:0];
        else
            oy = cfg.border_width;

        dsum = (RMOD_BITS + 1)'(ymod) + (RMOD_BITS + 1)'(oy);
        if (dsum >= (RMOD_BITS + 1)'(RING_ROWS))
            dmod = RMOD_BITS'(dsum - (RMOD_BITS + 1)'(RING_ROWS));
        else
            dmod = RMOD_BITS'(dsum);

        addr_c = ring_addr(ymod, x);
        addr_r = ring_addr(ymod, x + COL_BITS'(ox));
        addr_d = ring_addr(dmod, x);
        waddr  = ring_addr(in_rmod_reg, in_col_reg);

        // output position advance
        done          = 1'b0;
        out_col_next  = x;
        out_row_next  = y;
        out_rmod_next = ymod;
        if (emit)
        begin
            if (FW_BITS'(x) >= fw_m1)
            begin
                out_col_next = '0;
                if (y >= fh_m1)
                begin
                    out_row_next  = '0;
                    out_rmod_next = '0;
                    done          = 1'b1;
                end
                else
                begin
                    out_row_next  = y + ROW_BITS'(1);
                    out_rmod_next = (ymod == RMOD_BITS'(RING_ROWS - 1)) ? '0
                                  : ymod + RMOD_BITS'(1);
                end
            end
            else
            begin
                out_col_next = x + COL_BITS'(1);
            end
        end

        // input position advance
        last         = 1'b0;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_rmod_next = in_rmod_reg;
        if (is_pixel)
        begin
            if (FW_BITS'(in_col_reg) >= fw_m1)
            begin
                in_col_next = '0;
                if (in_row_reg >= fh_m1)
                begin
                    in_row_next  = '0;
                    in_rmod_next = '0;
                    last         = 1'b1;
                end
                else
                begin
                    in_row_next  = in_row_reg + ROW_BITS'(1);
                    in_rmod_next = (in_rmod_reg == RMOD_BITS'(RING_ROWS - 1)) ? '0
                                 : in_rmod_reg + RMOD_BITS'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_BITS'(1);
            end
        end

        if (is_pixel)
            tail_next = last && !(emit && done);
        else
            tail_next = tail_reg && !(emit && done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_rmod_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_rmod_reg <= '0;
            tail_reg     <= 1'b0;
            valid1_reg   <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                in_col_reg   <= in_col_next;
                in_row_reg   <= in_row_next;
                in_rmod_reg  <= in_rmod_next;
                out_col_reg  <= out_col_next;
                out_row_reg  <= out_row_next;
                out_rmod_reg <= out_rmod_next;
                tail_reg     <= tail_next;
            end
            if (adv)
            begin
                valid1_reg <= acc && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            done1_reg <= done;
            hit_c_reg <= is_pixel && (addr_c == waddr);
            hit_r_reg <= is_pixel && (addr_r == waddr);
            hit_d_reg <= is_pixel && (addr_d == waddr);
            wdata_reg <= pix;
        end
    end

    nge_ram #(.WIDTH(PIX_BITS), .DEPTH(RING_DEPTH)) u_ram_c (
        .clk   (clk),
        .we    (acc && is_pixel),
        .waddr (waddr),
        .wdata (pix),
        .re    (adv),
        .raddr (addr_c),
        .rdata (q_c)
    );

    nge_ram #(.WIDTH(PIX_BITS), .DEPTH(RING_DEPTH)) u_ram_r (
        .clk   (clk),
        .we    (acc && is_pixel),
        .waddr (waddr),
        .wdata (pix),
        .re    (adv),
        .raddr (addr_r),
        .rdata (q_r)
    );

    nge_ram #(.WIDTH(PIX_BITS), .DEPTH(RING_DEPTH)) u_ram_d (
        .clk   (clk),
        .we    (acc && is_pixel),
        .waddr (waddr),
        .wdata (pix),
        .re    (adv),
        .raddr (addr_d),
        .rdata (q_d)
    );

    assign f_valid = valid1_reg;
    assign f_done  = done1_reg;
    assign c_pix   = hit_c_reg ? wdata_reg : q_c;
    assign r_pix   = hit_r_reg ? wdata_reg : q_r;
    assign d_pix   = hit_d_reg ? wdata_reg : q_d;

endmodule

>>> rtl/core/nge_mag.sv
// Gradient magnitude pipeline: differences, squares, sum and shift, bit-per-stage root, clamp, optional inversion.
// Depends on nge_pkg; its last stage is the output register of the core.
module nge_mag
    import nge_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                adv,
    input  logic                f_valid,
    input  logic                f_done,
    input  logic [PIX_BITS-1:0] c_pix,
    input  logic [PIX_BITS-1:0] r_pix,
    input  logic [PIX_BITS-1:0] d_pix,
    output logic                o_valid,
    output logic                o_done,
    output logic [PIX_BITS-1:0] o_pix
);

    logic [CH_BITS-1:0] smax;
    logic [CH_BITS-1:0] cs [0:2];
    logic [CH_BITS-1:0] rs [0:2];
    logic [CH_BITS-1:0] ds [0:2];

    logic               va_reg, vb_reg, vc_reg;
    logic               da_reg, db_reg, dc_reg;
    logic [CH_BITS-1:0] aa_reg, ab_reg, ac_reg;
    logic [CH_BITS-1:0] d1_reg [0:2];
    logic [CH_BITS-1:0] d2_reg [0:2];
    logic [31:0]        s1_reg [0:2];
    logic [31:0]        s2_reg [0:2];

    sqrt_state_t        sq_reg [0:SQRT_STEPS][0:2];
    logic               sv_reg [1:SQRT_STEPS];
    logic               sd_reg [1:SQRT_STEPS];
    logic [CH_BITS-1:0] sa_reg [1:SQRT_STEPS];

    logic               out_valid_reg;
    logic               out_done_reg;
    logic [PIX_BITS-1:0] out_pix_reg;
    logic [PIX_BITS-1:0] out_pix_next;

    assign smax = cfg.sixteen_bit ? SMAX_WIDE : SMAX_NARROW;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cs[k] = c_pix[k*CH_BITS +: CH_BITS] & smax;
            rs[k] = r_pix[k*CH_BITS +: CH_BITS] & smax;
            ds[k] = d_pix[k*CH_BITS +: CH_BITS] & smax;
        end
    end

    always_comb
    begin
        logic [SQ_W-1:0] root;
        logic [CH_BITS-1:0] v;
        out_pix_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            root = sq_reg[SQRT_STEPS][k].root;
            v    = (root > SQ_W'(smax)) ? smax : CH_BITS'(root);
            out_pix_next[k*CH_BITS +: CH_BITS] = cfg.effect_mode ? (smax - v) : v;
        end
        out_pix_next[3*CH_BITS +: CH_BITS] = sa_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 1; s <= SQRT_STEPS; s++)
            begin
                sv_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            va_reg    <= f_valid;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            sv_reg[1] <= vc_reg;
            for (int s = 2; s <= SQRT_STEPS; s++)
            begin
                sv_reg[s] <= sv_reg[s-1];
            end
            out_valid_reg <= sv_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            da_reg <= f_done;
            aa_reg <= c_pix[3*CH_BITS +: CH_BITS];
            db_reg <= da_reg;
            ab_reg <= aa_reg;
            dc_reg <= db_reg;
            ac_reg <= ab_reg;
            for (int k = 0; k < 3; k++)
            begin
                d1_reg[k] <= (cs[k] > rs[k]) ? cs[k] - rs[k] : rs[k] - cs[k];
                d2_reg[k] <= (cs[k] > ds[k]) ? cs[k] - ds[k] : ds[k] - cs[k];
                s1_reg[k] <= 32'(d1_reg[k]) * 32'(d1_reg[k]);
                s2_reg[k] <= 32'(d2_reg[k]) * 32'(d2_reg[k]);
                sq_reg[0][k].rem  <= (SQ_W'(s1_reg[k]) + SQ_W'(s2_reg[k])) << cfg.intensity;
                sq_reg[0][k].root <= '0;
                for (int s = 0; s < SQRT_STEPS; s++)
                begin
                    sq_reg[s+1][k] <= sqrt_step(sq_reg[s][k],
                                                SQ_W'(1) << (SQ_W - 2 - 2 * s));
                end
            end
            sd_reg[1] <= dc_reg;
            sa_reg[1] <= ac_reg;
            for (int s = 2; s <= SQRT_STEPS; s++)
            begin
                sd_reg[s] <= sd_reg[s-1];
                sa_reg[s] <= sa_reg[s-1];
            end
            out_done_reg <= sd_reg[SQRT_STEPS];
            out_pix_reg  <= out_pix_next;
        end
    end

    assign o_valid = out_valid_reg;
    assign o_done  = out_done_reg;
    assign o_pix   = out_pix_reg;

endmodule

>>> rtl/core/neighbor_gradient_edge_filter_core.sv
// Neighbor gradient edge filter: BGRA stream in, gradient magnitude per color channel out.
// Connects nge_cfg, nge_fetch and nge_mag; depends on nge_pkg.
//
// Usage:
//   s_axis carries one item per handshake: tdata is a BGRA pixel, tuser
//   marks a pixel (0) or a drain item (1). Pixels arrive in raster order.
//   m_axis returns filtered pixels in raster order, border_width rows
//   behind the input; tlast marks the last pixel of a frame. After the
//   last pixel of a frame, send drain items to flush the pending rows.
//   The APB port sets frame size, mode, intensity, border and sample depth;
//   write it only while the core is idle. Out-of-range writes saturate.
// Timing:
//   One item per cycle sustained while m_axis does not stall. The path from
//   accept to m_axis_tvalid runs through one ring read, three arithmetic stages,
//   19 root stages (one result bit each) and the output register.
// Reset:
//   rst_n clears counters, pipeline valids and registers to their defaults.
// Stall:
//   When the output register holds an item that is not taken, the whole
//   pipeline holds and s_axis_tready drops; nothing is lost or repeated.
module neighbor_gradient_edge_filter_core
    import nge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // in_blue, in_green, in_red, in_alpha
    input  logic [0:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // out_blue, out_green, out_red, out_alpha
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t                cfg;
    logic                adv;
    logic                acc;
    logic                f_valid;
    logic                f_done;
    logic [PIX_BITS-1:0] c_pix, r_pix, d_pix;

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign acc = s_axis_tvalid && adv;
    assign s_axis_tready = adv;

    nge_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nge_fetch u_fetch (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .adv     (adv),
        .acc     (acc),
        .op      (s_axis_tuser[0]),
        .pix     (s_axis_tdata),
        .f_valid (f_valid),
        .f_done  (f_done),
        .c_pix   (c_pix),
        .r_pix   (r_pix),
        .d_pix   (d_pix)
    );

    nge_mag u_mag (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .adv     (adv),
        .f_valid (f_valid),
        .f_done  (f_done),
        .c_pix   (c_pix),
        .r_pix   (r_pix),
        .d_pix   (d_pix),
        .o_valid (m_axis_tvalid),
        .o_done  (m_axis_tlast),
        .o_pix   (m_axis_tdata)
    );

endmodule

>>> test/nge_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the neighbor gradient edge filter core: tracks APB writes and stream
// items, predicts every filtered pixel and compares it with m_axis. Depends on nge_pkg.
module nge_checker
    import nge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // in_blue, in_green, in_red, in_alpha
    input  logic [0:0]  s_axis_tuser,  // opcode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,  // out_blue, out_green, out_red, out_alpha
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          owed,
    output int          checked,
    output logic        tail_owed,
    output int          cur_width,
    output int          cur_height
);

    typedef struct {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
        logic [15:0] alpha;
        logic        frame_done;
    } filt_pixel_t;

    filt_pixel_t pixel_q[$];
    logic [63:0] ring [RING_DEPTH];
    int unsigned in_col, in_row, out_col, out_row;
    int unsigned width, height, mode, shift, border, wide;

    assign owed       = pixel_q.size();
    assign cur_width  = width;
    assign cur_height = height;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem, root, bitv;
        rem  = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic int unsigned near_step(input int unsigned pos, input int unsigned size);
        int unsigned room;
        if (pos >= size - 1)
            return 0;
        room = size - 1 - pos;
        return (room < border) ? room : border;
    endfunction

    function automatic logic [63:0] ring_at(input int unsigned col, input int unsigned row);
        return ring[(row % RING_ROWS) * MAX_WIDTH + (col % MAX_WIDTH)];
    endfunction

    function automatic logic [15:0] grad_channel(input logic [63:0] c, input logic [63:0] r,
                                                 input logic [63:0] d, input logic [63:0] smax);
        logic [63:0] d1, d2, v;
        d1 = (c > r) ? c - r : r - c;
        d2 = (c > d) ? c - d : d - c;
        v  = int_sqrt((d1 * d1 + d2 * d2) << shift);
        if (v > smax)
            v = smax;
        return 16'(mode ? smax - v : v);
    endfunction

    task automatic emit_filtered();
        filt_pixel_t p;
        logic [63:0] c, r, d, smax;
        smax = wide ? 64'hFFFF : 64'hFF;
        c = ring_at(out_col, out_row);
        r = ring_at(out_col + near_step(out_col, width), out_row);
        d = ring_at(out_col, out_row + near_step(out_row, height));
        p.blue  = grad_channel(c & smax, r & smax, d & smax, smax);
        p.green = grad_channel((c >> 16) & smax, (r >> 16) & smax, (d >> 16) & smax, smax);
        p.red   = grad_channel((c >> 32) & smax, (r >> 32) & smax, (d >> 32) & smax, smax);
        p.alpha = c[63:48];
        p.frame_done = 1'b0;
        if (out_col >= width - 1)
        begin
            out_col = 0;
            if (out_row >= height - 1)
            begin
                out_row = 0;
                p.frame_done = 1'b1;
            end
            else
                out_row++;
        end
        else
            out_col++;
        if (p.frame_done)
            tail_owed = 1'b0;
        pixel_q.push_back(p);
    endtask

    task automatic take_item(input logic op, input logic [63:0] data);
        logic last, done_now;
        if (op == OP_DRAIN)
        begin
            if (tail_owed)
                emit_filtered();
            return;
        end
        if (tail_owed)
        begin
            tail_owed = 1'b0;
            out_col = 0;
            out_row = 0;
        end
        ring[(in_row % RING_ROWS) * MAX_WIDTH + (in_col % MAX_WIDTH)] = data;
        last = 1'b0;
        done_now = 1'b0;
        if (in_row >= border)
        begin
            emit_filtered();
            done_now = pixel_q[$].frame_done;
        end
        if (in_col >= width - 1)
        begin
            in_col = 0;
            if (in_row >= height - 1)
            begin
                in_row = 0;
                last = 1'b1;
            end
            else
                in_row++;
        end
        else
            in_col++;
        if (last && !done_now)
            tail_owed = 1'b1;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        int unsigned x;
        case (reg_index_t'(idx))
            REG_FRAME_WIDTH:
            begin
                x = v[10:0];
                width = (x < 1) ? 1 : ((x > MAX_WIDTH) ? MAX_WIDTH : x);
            end
            REG_FRAME_HEIGHT:
            begin
                x = v[15:0];
                height = (x < 1) ? 1 : x;
            end
            REG_EFFECT_MODE:  mode = v[0];
            REG_INTENSITY:
            begin
                x = v[2:0];
                shift = (x > MAX_INTENSITY) ? MAX_INTENSITY : x;
            end
            REG_BORDER_WIDTH:
            begin
                x = v[2:0];
                border = (x < 1) ? 1 : ((x > MAX_BORDER) ? MAX_BORDER : x);
            end
            REG_SIXTEEN_BIT:  wide = v[0];
            default: ;
        endcase
    endtask

    task automatic compare_out();
        filt_pixel_t e;
        if (pixel_q.size() == 0)
        begin
            $error("unexpected output item: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
            errors++;
            return;
        end
        e = pixel_q.pop_front();
        checked++;
        if (m_axis_tdata[15:0] !== e.blue)
        begin
            $error("out_blue: expected %h, actual %h", e.blue, m_axis_tdata[15:0]);
            errors++;
        end
        if (m_axis_tdata[31:16] !== e.green)
        begin
            $error("out_green: expected %h, actual %h", e.green, m_axis_tdata[31:16]);
            errors++;
        end
        if (m_axis_tdata[47:32] !== e.red)
        begin
            $error("out_red: expected %h, actual %h", e.red, m_axis_tdata[47:32]);
            errors++;
        end
        if (m_axis_tdata[63:48] !== e.alpha)
        begin
            $error("out_alpha: expected %h, actual %h", e.alpha, m_axis_tdata[63:48]);
            errors++;
        end
        if (m_axis_tlast !== e.frame_done)
        begin
            $error("frame_done: expected %b, actual %b", e.frame_done, m_axis_tlast);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_q.delete();
            errors    = 0;
            checked   = 0;
            tail_owed = 1'b0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            width  = 1024;
            height = 1;
            mode   = 0;
            shift  = 3;
            border = 2;
            wide   = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                compare_out();
            if (s_axis_tvalid && s_axis_tready)
                take_item(s_axis_tuser[0], s_axis_tdata);
            if (psel && penable && pwrite && pready)
                write_reg(paddr[4:2], pwdata);
        end
    end

endmodule

>>> test/tb_neighbor_gradient_edge_filter_core.sv
`timescale 1ns / 100ps
// Top of the neighbor gradient edge filter testbench: clock, reset, APB setup,
// random frames with drains and idling; needs nge_pkg, the core and nge_checker.
module tb_neighbor_gradient_edge_filter_core;
    import nge_pkg::*;

    localparam int LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   errors, owed, checked, cur_width, cur_height;
    logic tail_owed;
    int   cycles;
    int   items;
    int   stall_left;
    logic quiet;

    neighbor_gradient_edge_filter_core u_top (.*);

    nge_checker u_chk (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_neighbor_gradient_edge_filter_core: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (quiet)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic apb_write(input reg_index_t idx, input logic [31:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] w, input logic [31:0] h, input logic [31:0] md,
                             input logic [31:0] sh, input logic [31:0] bw, input logic [31:0] wd);
        while (owed != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
        apb_write(REG_EFFECT_MODE, md);
        apb_write(REG_INTENSITY, sh);
        apb_write(REG_BORDER_WIDTH, bw);
        apb_write(REG_SIXTEEN_BIT, wd);
    endtask

    task automatic send_item(input opcode_t op, input logic [63:0] data);
        int gap;
        if (!quiet && $urandom_range(0, 6) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        items++;
    endtask

    task automatic flush_tail();
        while (tail_owed)
            send_item(OP_DRAIN, {$urandom, $urandom});
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_pixel();
        logic [63:0] p;
        logic [15:0] base;
        if ($urandom_range(0, 1))
            p = {$urandom, $urandom};
        else
        begin
            base = 16'($urandom);
            p = {base + 16'($urandom_range(0, 40)), base + 16'($urandom_range(0, 40)),
                 base + 16'($urandom_range(0, 40)), base + 16'($urandom_range(0, 40))};
        end
        return p;
    endfunction

    task automatic send_frame();
        int n;
        n = cur_width * cur_height;
        repeat (n) send_item(OP_PIXEL, rand_pixel());
    endtask

    logic [63:0] corner_px [8] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
                                   64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                                   64'hFFFF_0000_FFFF_0000, 64'h0001_8000_00FF_FF00,
                                   64'h8000_0001_FF00_00FF};

    initial
    begin
        int frames, k;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PIXEL;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cycles        = 0;
        items         = 0;
        stall_left    = 0;
        quiet         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        configure(3, 3, 0, 5, 1, 1);
        send_item(OP_DRAIN, 64'hFFFF_FFFF_FFFF_FFFF);
        for (k = 0; k < 9; k++)
            send_item(OP_PIXEL, corner_px[k % 8]);
        flush_tail();
        configure(3, 3, 1, 0, 1, 0);
        for (k = 0; k < 9; k++)
            send_item(OP_PIXEL, corner_px[(k + 3) % 8]);
        flush_tail();

        configure(32'hFFFF_F800, 32'hFFFF_0000, 32'd2, 7, 7, 32'd3);
        send_frame();
        flush_tail();

        while (items < 950)
        begin
            if (items > 800)
                quiet = 1'b1;
            configure($urandom_range(0, 5) == 0 ? 32'(0)
                                                : {21'($urandom), 11'($urandom_range(1, 12))},
                      {16'($urandom), 16'($urandom_range(0, 8))}, $urandom, $urandom,
                      $urandom, $urandom);
            frames = $urandom_range(1, 3);
            for (k = 0; k < frames; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_item(OP_DRAIN, {$urandom, $urandom});
                send_frame();
                if (k < frames - 1)
                    repeat ($urandom_range(0, 3)) send_item(OP_DRAIN, {$urandom, $urandom});
            end
            flush_tail();
        end

        quiet = 1'b1;
        while (owed != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d input items and %0d filtered pixels over many frame setups,",
                 items, checked);
        $display("both sample depths, both modes, saturated register writes and abandoned tails");
        if (errors == 0 && owed == 0)
            $display("tb_neighbor_gradient_edge_filter_core: done, clean");
        else
            $display("tb_neighbor_gradient_edge_filter_core: done, errors");
        $finish;
    end

endmodule

>>> files.f
rtl/core/nge_pkg.sv
rtl/core/nge_ram.sv
rtl/core/nge_cfg.sv
rtl/core/nge_fetch.sv
rtl/core/nge_mag.sv
rtl/core/neighbor_gradient_edge_filter_core.sv
test/nge_checker.sv
test/tb_neighbor_gradient_edge_filter_core.sv
